@@ rtl/mwo_pkg.sv @@
// Shared types and constants for the multi-waveform oscillator.
// Used by the sine ROM and the top level; no dependencies.
`default_nettype none

package mwo_pkg;

    localparam int AMP_BITS       = 15;
    localparam int SAMPLE_BITS    = 16;
    localparam int INDEX_BITS     = 24;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int SINE_MAG_BITS  = 15;
    localparam int SINE_PROD_BITS = SINE_MAG_BITS + AMP_BITS;

    localparam logic [SINE_MAG_BITS-1:0] SINE_FULL_SCALE = 15'd32767;
    localparam logic [INDEX_BITS-1:0]    SAMPLE_COUNT_RESET = 24'd44100;

    typedef logic [AMP_BITS-1:0]      amp_t;
    typedef logic [SINE_MAG_BITS-1:0] sine_mag_t;
    typedef logic [INDEX_BITS-1:0]    sample_index_t;
    typedef logic [SAMPLE_BITS-1:0]   sample_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PHASE_STEP   = 3'd0,
        REG_CHIRP_START  = 3'd1,
        REG_CHIRP_SWEEP  = 3'd2,
        REG_AMPLITUDE    = 3'd3,
        REG_SAMPLE_COUNT = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

@@ rtl/mwo_sine_rom.sv @@
// Quarter-wave sine ROM with a registered read port.
// The table is computed at elaboration with integer Taylor terms; uses mwo_pkg.
`default_nettype none

module mwo_sine_rom #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire                          clk,
    input  wire                          rd_en,
    input  wire  [SINE_TABLE_BITS:0]     rd_addr,
    output logic [mwo_pkg::SINE_MAG_BITS-1:0] rd_data
);

    localparam int DEPTH = (1 << SINE_TABLE_BITS) + 1;

    typedef logic [mwo_pkg::SINE_MAG_BITS-1:0] rom_t [DEPTH];

    function automatic rom_t build_table();
        rom_t            tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned e;
        longint unsigned p;
        for (int k = 0; k < DEPTH; k++)
        begin
            x  = (64'd1686629713 * longint'(k)) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            for (int j = 0; j < 6; j++)
            begin
                p = (x2 * t) >> 30;
                case (j)
                    0:       t = (64'd1 << 30) - p / 64'd156;
                    1:       t = (64'd1 << 30) - p / 64'd110;
                    2:       t = (64'd1 << 30) - p / 64'd72;
                    3:       t = (64'd1 << 30) - p / 64'd42;
                    4:       t = (64'd1 << 30) - p / 64'd20;
                    default: t = (64'd1 << 30) - p / 64'd6;
                endcase
            end
            s = (x * t) >> 30;
            e = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            if (e > 64'd32767)
            begin
                e = 64'd32767;
            end
            tab[k] = mwo_pkg::SINE_MAG_BITS'(e);
        end
        return tab;
    endfunction

    localparam rom_t SINE_ROM = build_table();

    logic [mwo_pkg::SINE_MAG_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= SINE_ROM[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/multi_waveform_oscillator.sv @@
// Four-waveform oscillator: chirped sine, square, sawtooth and triangle samples.
// Throughput is one sample per cycle while m_axis_tready does not hold the output; the sine
// ROM read and the scaling multipliers each occupy one registered stage of the three-stage
// pipeline.
// Reset clears the phases, chirp increment, sample counter and pipeline valids,
// and loads the register defaults (run length 44100, all others zero).
// Depends on mwo_pkg and mwo_sine_rom.
`default_nettype none

module multi_waveform_oscillator #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire         clk,
    input  wire         rst_n,

    input  wire         cfg_write,
    input  wire  [mwo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire  [mwo_pkg::CFG_DATA_BITS-1:0]  cfg_data,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] sine_out, [31:16] square_out,
                                        // [47:32] saw_out, [63:48] triangle_out
    output logic        m_axis_tlast
);

    localparam int MAG_BITS  = PHASE_BITS + 1;
    localparam int WIDE_BITS = PHASE_BITS + 2;
    localparam int PROD_BITS = MAG_BITS + mwo_pkg::AMP_BITS;

    localparam logic [MAG_BITS-1:0]  PFULL_M = MAG_BITS'(1) << PHASE_BITS;
    localparam logic [WIDE_BITS-1:0] PFULL_W = WIDE_BITS'(1) << PHASE_BITS;
    localparam logic [WIDE_BITS-1:0] PTOP3_W = PFULL_W + (PFULL_W << 1);

    // Configuration registers.
    logic [PHASE_BITS-1:0]      phase_step_reg;
    logic [PHASE_BITS-1:0]      chirp_start_reg;
    logic [PHASE_BITS-1:0]      chirp_sweep_reg;
    mwo_pkg::amp_t              amplitude_reg;
    mwo_pkg::sample_index_t     sample_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= '0;
            chirp_start_reg  <= '0;
            chirp_sweep_reg  <= '0;
            amplitude_reg    <= '0;
            sample_count_reg <= mwo_pkg::SAMPLE_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mwo_pkg::REG_PHASE_STEP:   phase_step_reg   <= PHASE_BITS'(cfg_data);
                mwo_pkg::REG_CHIRP_START:  chirp_start_reg  <= PHASE_BITS'(cfg_data);
                mwo_pkg::REG_CHIRP_SWEEP:  chirp_sweep_reg  <= PHASE_BITS'(cfg_data);
                mwo_pkg::REG_AMPLITUDE:    amplitude_reg    <= cfg_data[mwo_pkg::AMP_BITS-1:0];
                mwo_pkg::REG_SAMPLE_COUNT:
                    sample_count_reg <= cfg_data[mwo_pkg::INDEX_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake: each stage accepts when empty or when it drains.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic m_valid_reg;
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;
    logic accept;
    logic s2_load;
    logic s3_load;

    assign s3_ready      = !m_valid_reg || m_axis_tready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;
    assign accept        = s_axis_tvalid && s1_ready;
    assign s2_load       = s1_valid_reg && s2_ready;
    assign s3_load       = s2_valid_reg && s3_ready;

    // Oscillator state.
    logic [PHASE_BITS-1:0]  lp_reg;
    logic [PHASE_BITS-1:0]  cp_reg;
    logic [PHASE_BITS-1:0]  ci_reg;
    mwo_pkg::sample_index_t idx_reg;

    logic                   restart;
    logic [PHASE_BITS-1:0]  lp_cur;
    logic [PHASE_BITS-1:0]  cp_cur;
    logic [PHASE_BITS-1:0]  ci_cur;
    mwo_pkg::sample_index_t idx_cur;
    mwo_pkg::sample_index_t last_index;
    logic                   last_cur;
    logic [PHASE_BITS-1:0]  lp_next;
    logic [PHASE_BITS-1:0]  cp_next;
    logic [PHASE_BITS-1:0]  ci_next;
    mwo_pkg::sample_index_t idx_next;

    assign restart    = s_axis_tdata[0];
    assign lp_cur     = restart ? '0 : lp_reg;
    assign cp_cur     = restart ? '0 : cp_reg;
    assign ci_cur     = restart ? chirp_start_reg : ci_reg;
    assign idx_cur    = restart ? '0 : idx_reg;
    assign last_index = sample_count_reg - mwo_pkg::INDEX_BITS'(1);
    assign last_cur   = idx_cur == last_index;
    assign lp_next    = lp_cur + phase_step_reg;
    assign cp_next    = cp_cur + ci_cur;
    assign ci_next    = ci_cur + chirp_sweep_reg;
    assign idx_next   = last_cur ? '0 : idx_cur + mwo_pkg::INDEX_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg  <= '0;
            cp_reg  <= '0;
            ci_reg  <= '0;
            idx_reg <= '0;
        end
        else if (accept)
        begin
            lp_reg  <= lp_next;
            cp_reg  <= cp_next;
            ci_reg  <= ci_next;
            idx_reg <= idx_next;
        end
    end

    // Sine table address from the chirp phase quadrant and index.
    logic [1:0]                 quadrant;
    logic [SINE_TABLE_BITS-1:0] sine_i;
    logic [SINE_TABLE_BITS:0]   rom_addr;
    mwo_pkg::sine_mag_t         rom_data;

    assign quadrant = cp_cur[PHASE_BITS-1 -: 2];
    assign sine_i   = cp_cur[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign rom_addr = quadrant[0]
                    ? (SINE_TABLE_BITS+1)'(1 << SINE_TABLE_BITS) - {1'b0, sine_i}
                    : {1'b0, sine_i};

    mwo_sine_rom #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_sine_rom (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    // Sawtooth and triangle magnitudes from the linear phase.
    logic [MAG_BITS-1:0]  lp2;
    logic [WIDE_BITS-1:0] lp4;
    logic [MAG_BITS-1:0]  saw_mag;
    logic                 saw_neg;
    logic [MAG_BITS-1:0]  tri_mag;
    logic                 tri_neg;

    assign lp2 = {lp_cur, 1'b0};
    assign lp4 = {lp_cur, 2'b00};

    always_comb
    begin
        if (lp_cur[PHASE_BITS-1])
        begin
            saw_mag = lp2 - PFULL_M;
            saw_neg = 1'b0;
            if (lp4 <= PTOP3_W)
            begin
                tri_mag = MAG_BITS'(PTOP3_W - lp4);
                tri_neg = 1'b0;
            end
            else
            begin
                tri_mag = MAG_BITS'(lp4 - PTOP3_W);
                tri_neg = 1'b1;
            end
        end
        else
        begin
            saw_mag = PFULL_M - lp2;
            saw_neg = 1'b1;
            if (lp4 >= PFULL_W)
            begin
                tri_mag = MAG_BITS'(lp4 - PFULL_W);
                tri_neg = 1'b0;
            end
            else
            begin
                tri_mag = MAG_BITS'(PFULL_W - lp4);
                tri_neg = 1'b1;
            end
        end
    end

    // Stage 1: input register alongside the ROM read.
    logic                s1_sine_neg_reg;
    logic                s1_sq_neg_reg;
    logic [MAG_BITS-1:0] s1_saw_mag_reg;
    logic                s1_saw_neg_reg;
    logic [MAG_BITS-1:0] s1_tri_mag_reg;
    logic                s1_tri_neg_reg;
    logic                s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sine_neg_reg <= quadrant[1];
            s1_sq_neg_reg   <= lp_cur[PHASE_BITS-1];
            s1_saw_mag_reg  <= saw_mag;
            s1_saw_neg_reg  <= saw_neg;
            s1_tri_mag_reg  <= tri_mag;
            s1_tri_neg_reg  <= tri_neg;
            s1_last_reg     <= last_cur;
        end
    end

    // Stage 2: amplitude scaling products.
    logic [mwo_pkg::SINE_PROD_BITS-1:0] sine_prod;
    logic [PROD_BITS-1:0]               saw_prod;
    logic [PROD_BITS-1:0]               tri_prod;

    assign sine_prod = rom_data * amplitude_reg;
    assign saw_prod  = PROD_BITS'(s1_saw_mag_reg) * PROD_BITS'(amplitude_reg);
    assign tri_prod  = PROD_BITS'(s1_tri_mag_reg) * PROD_BITS'(amplitude_reg);

    logic [mwo_pkg::SINE_PROD_BITS-1:0] s2_sine_prod_reg;
    logic                               s2_sine_neg_reg;
    logic                               s2_sq_neg_reg;
    mwo_pkg::amp_t                      s2_saw_reg;
    logic                               s2_saw_neg_reg;
    mwo_pkg::amp_t                      s2_tri_reg;
    logic                               s2_tri_neg_reg;
    logic                               s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_sine_prod_reg <= sine_prod;
            s2_sine_neg_reg  <= s1_sine_neg_reg;
            s2_sq_neg_reg    <= s1_sq_neg_reg;
            s2_saw_reg       <= saw_prod[PHASE_BITS +: mwo_pkg::AMP_BITS];
            s2_saw_neg_reg   <= s1_saw_neg_reg;
            s2_tri_reg       <= tri_prod[PHASE_BITS +: mwo_pkg::AMP_BITS];
            s2_tri_neg_reg   <= s1_tri_neg_reg;
            s2_last_reg      <= s1_last_reg;
        end
    end

    // Stage 3: divide the sine product by full scale, then apply signs.
    // The quotient by 2^15 is low by at most one against the quotient by 2^15 - 1.
    mwo_pkg::sine_mag_t  sine_q0;
    logic [15:0]         sine_rem;
    mwo_pkg::sine_mag_t  sine_q;

    assign sine_q0  = s2_sine_prod_reg[mwo_pkg::SINE_PROD_BITS-1 -: mwo_pkg::SINE_MAG_BITS];
    assign sine_rem = {1'b0, s2_sine_prod_reg[mwo_pkg::SINE_MAG_BITS-1:0]} + {1'b0, sine_q0};
    assign sine_q   = (sine_rem >= {1'b0, mwo_pkg::SINE_FULL_SCALE})
                    ? sine_q0 + mwo_pkg::SINE_MAG_BITS'(1) : sine_q0;

    function automatic mwo_pkg::sample_t apply_sign(input logic neg, input logic [14:0] mag);
        return neg ? mwo_pkg::sample_t'(-{1'b0, mag}) : {1'b0, mag};
    endfunction

    mwo_pkg::sample_t sine_out_reg;
    mwo_pkg::sample_t square_out_reg;
    mwo_pkg::sample_t saw_out_reg;
    mwo_pkg::sample_t triangle_out_reg;
    logic             last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            sine_out_reg     <= apply_sign(s2_sine_neg_reg, sine_q);
            square_out_reg   <= apply_sign(s2_sq_neg_reg, amplitude_reg);
            saw_out_reg      <= apply_sign(s2_saw_neg_reg, s2_saw_reg);
            triangle_out_reg <= apply_sign(s2_tri_neg_reg, s2_tri_reg);
            last_reg         <= s2_last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {triangle_out_reg, saw_out_reg, square_out_reg, sine_out_reg};
    assign m_axis_tlast  = last_reg;

    // A transaction with restart starts the linear phase from zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && restart |=> lp_reg == $past(phase_step_reg))
        else $error("linear phase did not restart from zero");

    // After restart, the chirp increment is the start value plus one sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && restart |=> ci_reg == $past(chirp_start_reg + chirp_sweep_reg))
        else $error("chirp increment not reloaded on restart");

    // The counter wraps to zero right after the last sample of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_cur |=> idx_reg == '0)
        else $error("sample counter did not wrap after the last sample");

    // Every accepted transaction enters the first pipeline stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transaction lost at stage 1");

endmodule

`default_nettype wire

@@ tb/sv/tb_multi_waveform_oscillator.sv @@
// Self-checking testbench for multi_waveform_oscillator: directed and random stimulus
// with stream back-pressure, checked against a cycle-free behavioral predictor.
// Depends on mwo_pkg and the oscillator RTL.

module tb_multi_waveform_oscillator;

    localparam int TABLE_BITS = 10;
    localparam int QUARTER = 1 << TABLE_BITS;
    localparam int PIPE_LATENCY = 3;
    localparam int IDLE_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;
    localparam longint unsigned HALF_CYCLE = 64'h8000_0000;
    localparam longint unsigned FULL_CYCLE = 64'h1_0000_0000;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    typedef struct {
        mwo_pkg::sample_t sine;
        mwo_pkg::sample_t square;
        mwo_pkg::sample_t saw;
        mwo_pkg::sample_t triangle;
        logic             last;
    } wave_sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [mwo_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [mwo_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic m_axis_tlast;

    logic [31:0] cfg_step, cfg_chirp_start, cfg_chirp_sweep;
    mwo_pkg::amp_t cfg_amp;
    mwo_pkg::sample_index_t cfg_run_len;
    logic [31:0] osc_lin_phase, osc_chirp_phase, osc_chirp_incr;
    mwo_pkg::sample_index_t osc_index;
    mwo_pkg::sine_mag_t sine_quarter [0:QUARTER];

    wave_sample_t pending_samples [$];
    int mismatches = 0;
    bit tx_gaps = 1'b0;
    bit rx_stalls = 1'b0;
    int rx_hold_len = 0;

    multi_waveform_oscillator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    function automatic void build_sine_quarter();
        int unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned x, x2, t, s, e;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x = (HALF_PI_Q30 * longint'(k)) >> TABLE_BITS;
            x2 = (x * x) >> 30;
            t = ONE_Q30;
            for (int j = 0; j < 6; j++)
            begin
                t = ONE_Q30 - ((x2 * t) >> 30) / divs[j];
            end
            s = (x * t) >> 30;
            e = (s * 32767 + (64'd1 << 29)) >> 30;
            if (e > mwo_pkg::SINE_FULL_SCALE)
                e = mwo_pkg::SINE_FULL_SCALE;
            sine_quarter[k] = mwo_pkg::sine_mag_t'(e);
        end
    endfunction

    function automatic void reset_oscillator_model();
        cfg_step = '0;
        cfg_chirp_start = '0;
        cfg_chirp_sweep = '0;
        cfg_amp = '0;
        cfg_run_len = mwo_pkg::SAMPLE_COUNT_RESET;
        osc_lin_phase = '0;
        osc_chirp_phase = '0;
        osc_chirp_incr = '0;
        osc_index = '0;
    endfunction

    function automatic void apply_setting(logic [mwo_pkg::CFG_INDEX_BITS-1:0] idx,
                                          logic [mwo_pkg::CFG_DATA_BITS-1:0] val);
        case (idx)
            mwo_pkg::REG_PHASE_STEP:   cfg_step = val;
            mwo_pkg::REG_CHIRP_START:  cfg_chirp_start = val;
            mwo_pkg::REG_CHIRP_SWEEP:  cfg_chirp_sweep = val;
            mwo_pkg::REG_AMPLITUDE:    cfg_amp = val[mwo_pkg::AMP_BITS-1:0];
            mwo_pkg::REG_SAMPLE_COUNT: cfg_run_len = val[mwo_pkg::INDEX_BITS-1:0];
            default:                   ;
        endcase
    endfunction

    function automatic mwo_pkg::sample_t apply_sign(bit neg, longint unsigned mag);
        return neg ? mwo_pkg::sample_t'(-mag) : mwo_pkg::sample_t'(mag);
    endfunction

    function automatic mwo_pkg::sample_t scale_by_amp(bit neg, longint unsigned mag);
        return apply_sign(neg, (mag * cfg_amp) >> 32);
    endfunction

    function automatic wave_sample_t synth_sample(bit restart);
        wave_sample_t w;
        logic [1:0] quad;
        logic [TABLE_BITS-1:0] tidx;
        longint unsigned smag, lp, f;
        if (restart)
        begin
            osc_lin_phase = '0;
            osc_chirp_phase = '0;
            osc_chirp_incr = cfg_chirp_start;
            osc_index = '0;
        end
        lp = osc_lin_phase;
        quad = osc_chirp_phase[31:30];
        tidx = osc_chirp_phase[29 -: TABLE_BITS];
        smag = quad[0] ? sine_quarter[QUARTER - tidx] : sine_quarter[tidx];
        w.sine = apply_sign(quad[1], (smag * cfg_amp) / mwo_pkg::SINE_FULL_SCALE);
        w.square = apply_sign(lp >= HALF_CYCLE, cfg_amp);
        if (lp >= HALF_CYCLE)
            w.saw = scale_by_amp(1'b0, 2 * (lp - HALF_CYCLE));
        else
            w.saw = scale_by_amp(1'b1, 2 * (HALF_CYCLE - lp));
        f = 4 * lp;
        if (lp < HALF_CYCLE)
            w.triangle = (f >= FULL_CYCLE) ? scale_by_amp(1'b0, f - FULL_CYCLE)
                                           : scale_by_amp(1'b1, FULL_CYCLE - f);
        else
            w.triangle = (f <= 3 * FULL_CYCLE) ? scale_by_amp(1'b0, 3 * FULL_CYCLE - f)
                                               : scale_by_amp(1'b1, f - 3 * FULL_CYCLE);
        w.last = osc_index == mwo_pkg::sample_index_t'(cfg_run_len - 1'b1);
        osc_lin_phase += cfg_step;
        osc_chirp_phase += osc_chirp_incr;
        osc_chirp_incr += cfg_chirp_sweep;
        osc_index = w.last ? '0 : osc_index + 1'b1;
        return w;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic void report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function automatic void check_field(string name, mwo_pkg::sample_t got,
                                        mwo_pkg::sample_t want);
        if (got !== want)
            report_mismatch($sformatf("%s expected %0d, got %0d",
                                      name, $signed(want), $signed(got)));
    endfunction

    task automatic write_reg(logic [mwo_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [mwo_pkg::CFG_DATA_BITS-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        apply_setting(idx, val);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_sample(bit restart);
        int gap;
        wave_sample_t predicted;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, restart};
        do @(posedge clk); while (!s_axis_tready);
        predicted = synth_sample(restart);
        pending_samples.insert(pending_samples.size(), predicted);
        @(negedge clk);
    endtask

    task automatic send_burst(int count);
        for (int k = 0; k < count; k++)
        begin
            send_sample($urandom_range(0, 24) == 0);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(negedge clk);
        repeat (PIPE_LATENCY + 1) @(negedge clk);
    endtask

    task automatic test_reset_defaults();
        send_sample(1'b0);
        send_sample(1'b0);
        wait_idle();
    endtask

    task automatic test_quarter_phases();
        write_reg(mwo_pkg::REG_AMPLITUDE, 32'd32767);
        write_reg(mwo_pkg::REG_PHASE_STEP, 32'h4000_0000);
        write_reg(mwo_pkg::REG_CHIRP_START, 32'h4000_0000);
        write_reg(mwo_pkg::REG_CHIRP_SWEEP, 32'h0);
        write_reg(mwo_pkg::REG_SAMPLE_COUNT, 32'd3);
        send_sample(1'b1);
        repeat (4) send_sample(1'b0);
        send_sample(1'b1);
        repeat (2) send_sample(1'b0);
        wait_idle();
    endtask

    task automatic test_extreme_settings();
        write_reg(mwo_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(mwo_pkg::REG_CHIRP_START, 32'hFFFF_FFFF);
        write_reg(mwo_pkg::REG_CHIRP_SWEEP, 32'hFFFF_FFFF);
        write_reg(mwo_pkg::REG_AMPLITUDE, 32'd1);
        write_reg(mwo_pkg::REG_SAMPLE_COUNT, 32'd1);
        // Writes to unmapped indexes must leave every setting untouched.
        for (int idx = mwo_pkg::REG_SAMPLE_COUNT + 1; idx < (1 << mwo_pkg::CFG_INDEX_BITS);
             idx++)
        begin
            write_reg(mwo_pkg::CFG_INDEX_BITS'(idx), 32'hFFFF_FFFF);
        end
        send_sample(1'b1);
        repeat (3) send_sample(1'b0);
        wait_idle();
    endtask

    task automatic test_zero_amplitude();
        write_reg(mwo_pkg::REG_AMPLITUDE, 32'd0);
        write_reg(mwo_pkg::REG_PHASE_STEP, $urandom);
        send_sample(1'b1);
        send_sample(1'b0);
        wait_idle();
    endtask

    task automatic test_run_length();
        write_reg(mwo_pkg::REG_AMPLITUDE, 32'd20000);
        write_reg(mwo_pkg::REG_CHIRP_SWEEP, 32'h0001_0000);
        write_reg(mwo_pkg::REG_SAMPLE_COUNT, 32'd0);
        send_sample(1'b1);
        send_sample(1'b0);
        wait_idle();
        write_reg(mwo_pkg::REG_SAMPLE_COUNT, 32'd10);
        send_sample(1'b1);
        repeat (4) send_sample(1'b0);
        wait_idle();
        // The counter is now beyond the shortened run and must keep counting.
        write_reg(mwo_pkg::REG_SAMPLE_COUNT, 32'd3);
        repeat (3) send_sample(1'b0);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        tx_gaps = 1'b0;
        rx_stalls = 1'b1;
        write_reg(mwo_pkg::REG_SAMPLE_COUNT, 32'd7);
        rx_hold_len = 200;
        send_sample(1'b1);
        send_burst(39);
        wait_idle();
    endtask

    task automatic test_sender_pause();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        write_reg(mwo_pkg::REG_PHASE_STEP, $urandom);
        send_sample(1'b1);
        send_burst(19);
        wait_idle();
        send_burst(20);
        wait_idle();
    endtask

    task automatic test_random_runs();
        logic [31:0] step, amp, run_len;
        for (int run = 0; run < 8; run++)
        begin
            tx_gaps = (run % 4) != 3;
            rx_stalls = (run % 3) != 2;
            case (run % 4)
                0:       step = 32'hFFFF_FFFF;
                1:       step = $urandom_range(0, 32'h00FF_FFFF);
                default: step = $urandom;
            endcase
            case (run)
                1:       amp = 32767;
                2:       amp = 0;
                4:       amp = 1;
                default: amp = $urandom_range(0, 32767);
            endcase
            case (run)
                3:       run_len = 1;
                5:       run_len = 0;
                6:       run_len = 32'h00FF_FFFF;
                default: run_len = $urandom_range(1, 60);
            endcase
            write_reg(mwo_pkg::REG_PHASE_STEP, step);
            write_reg(mwo_pkg::REG_CHIRP_START, (run == 0) ? 32'hFFFF_FFFF : $urandom);
            write_reg(mwo_pkg::REG_CHIRP_SWEEP,
                      (run % 2) ? $urandom_range(0, 32'h0000_FFFF) : $urandom);
            write_reg(mwo_pkg::REG_AMPLITUDE, amp);
            write_reg(mwo_pkg::REG_SAMPLE_COUNT, run_len);
            send_sample(1'b1);
            send_burst(86);
            wait_idle();
        end
    endtask

    initial
    begin : sink_pacing
        int n;
        forever
        begin
            @(negedge clk);
            n = 1;
            if (rx_hold_len > 0)
            begin
                m_axis_tready <= 1'b0;
                n = rx_hold_len;
                rx_hold_len = 0;
            end
            else if (rx_stalls && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                n = pick_gap();
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
            repeat (n - 1) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        wave_sample_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_samples.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transaction data %h last %b",
                                          m_axis_tdata, m_axis_tlast));
            end
            else
            begin
                want = pending_samples.pop_front();
                check_field("sine_out", m_axis_tdata[15:0], want.sine);
                check_field("square_out", m_axis_tdata[31:16], want.square);
                check_field("saw_out", m_axis_tdata[47:32], want.saw);
                check_field("triangle_out", m_axis_tdata[63:48], want.triangle);
                check_field("last", mwo_pkg::sample_t'(m_axis_tlast),
                            mwo_pkg::sample_t'(want.last));
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_write)
                idle = 0;
            else
                idle++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        build_sine_quarter();
        reset_oscillator_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_quarter_phases();
        test_extreme_settings();
        test_zero_amplitude();
        test_run_length();
        test_output_backpressure();
        test_sender_pause();
        test_random_runs();
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_samples.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
